@@ rtl/drle_pkg.sv @@
// Package for the DCT coefficient zero-run-length encoder.
// Holds the result kinds, the configuration register indexes, the task record
// and the field widths. Depends on nothing.
`timescale 1ns / 1ps

package drle_pkg;

  localparam int COEFF_W    = 16;
  localparam int BLKNUM_W   = 24;
  localparam int RUN_W      = 9;
  localparam int SIDE_CFG_W = 5;
  localparam int HP_CFG_W   = 9;
  localparam int THR_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int KIND_W     = 3;

  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HI_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_HI          = 3'd0,
    KIND_BLOCK_START = 3'd1,
    KIND_BLOCK_NUM   = 3'd2,
    KIND_RUN_START   = 3'd3,
    KIND_RUN_LEN     = 3'd4,
    KIND_LO          = 3'd5
  } kind_t;

  // One bit per possible result of an item, in emission order.
  localparam int NSLOT       = 9;
  localparam int SLOT_IDX_W  = 4;
  localparam int SL_BS_PRE   = 0;
  localparam int SL_BN_PRE   = 1;
  localparam int SL_HI       = 2;
  localparam int SL_BS_POST  = 3;
  localparam int SL_BN_POST  = 4;
  localparam int SL_RL_PRE   = 5;
  localparam int SL_LO       = 6;
  localparam int SL_RS       = 7;
  localparam int SL_RL_END   = 8;

  typedef struct packed {
    logic [NSLOT-1:0]          mask;
    logic signed [COEFF_W-1:0] coeff;
    logic [BLKNUM_W-1:0]       blk;
    logic [RUN_W-1:0]          run;
  } task_t;

  function automatic kind_t slot_kind(input logic [SLOT_IDX_W-1:0] idx);
    kind_t k;
    case (idx)
      SLOT_IDX_W'(SL_BS_PRE):  k = KIND_BLOCK_START;
      SLOT_IDX_W'(SL_BN_PRE):  k = KIND_BLOCK_NUM;
      SLOT_IDX_W'(SL_HI):      k = KIND_HI;
      SLOT_IDX_W'(SL_BS_POST): k = KIND_BLOCK_START;
      SLOT_IDX_W'(SL_BN_POST): k = KIND_BLOCK_NUM;
      SLOT_IDX_W'(SL_RL_PRE):  k = KIND_RUN_LEN;
      SLOT_IDX_W'(SL_LO):      k = KIND_LO;
      SLOT_IDX_W'(SL_RS):      k = KIND_RUN_START;
      SLOT_IDX_W'(SL_RL_END):  k = KIND_RUN_LEN;
      default:                 k = KIND_HI;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/dct_run_length_encoder.sv @@
// Top level of the DCT coefficient zero-run-length encoder.
// Instantiates drle_front, drle_queue and drle_back; uses drle_pkg.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------------
//  in_      | input     | in_valid/in_stall  | in_coeff (16b signed)
//  out_     | output    | out_valid/out_stall| out_kind, out_coeff_out, out_count_out,
//           |           |                    | out_last_of_item
//  cfg_     | input     | cfg_we             | cfg_index (2b), cfg_data (16b)
//
// The front end takes one coefficient transfer per cycle while the four-entry
// task queue has room; each coefficient is classified in that cycle.
// The back end sends one result per cycle unless out_stall holds it; an item
// takes one output transfer per result (zero to four); the output port sets the rate.
// A result passes through the queue, cur_r and the output register to out_valid.
// Reset is synchronous and active low; it restores the default configuration,
// clears block position, block number and the open run, and empties the queue.
// A stall on the output fills the queue and then raises in_stall.

module dct_run_length_encoder #(
  parameter int MAX_BLOCK_SIDE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [drle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [drle_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [drle_pkg::COEFF_W-1:0] in_coeff,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [drle_pkg::KIND_W-1:0]         out_kind,
  output logic signed [drle_pkg::COEFF_W-1:0] out_coeff_out,
  output logic [drle_pkg::BLKNUM_W-1:0]       out_count_out,
  output logic                                out_last_of_item
);

  // Tasks carry a bit per possible result plus the values those results need.
  logic            q_push, q_full, q_pop, q_valid;
  drle_pkg::task_t push_task, head_task;

  drle_front #(
    .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_coeff  (in_coeff),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_task    (push_task)
  );

  // Items that only extend a zero run produce no task and skip the queue.
  drle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_task  (push_task),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_task  (head_task)
  );

  drle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_task           (head_task),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_coeff_out    (out_coeff_out),
    .out_count_out    (out_count_out),
    .out_last_of_item (out_last_of_item)
  );

endmodule

@@ rtl/drle_front.sv @@
// Front end of the encoder: configuration registers, block position, block
// number and zero-run tracking. Classifies each coefficient into a task.
// Depends on drle_pkg.
`timescale 1ns / 1ps

module drle_front #(
  parameter int MAX_BLOCK_SIDE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [drle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [drle_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [drle_pkg::COEFF_W-1:0] in_coeff,
  input  logic                                q_full,
  output logic                                q_push,
  output drle_pkg::task_t                     q_task
);

  localparam int MAXSQ = MAX_BLOCK_SIDE * MAX_BLOCK_SIDE;
  localparam int SW    = $clog2(MAX_BLOCK_SIDE + 1);
  localparam int TW    = $clog2(MAXSQ + 1);
  localparam int PW    = (MAXSQ > 1) ? $clog2(MAXSQ) : 1;
  localparam int CMPW  = ((TW > drle_pkg::HP_CFG_W) ? TW : drle_pkg::HP_CFG_W) + 1;

  logic [drle_pkg::SIDE_CFG_W-1:0] side_cfg_r;
  logic [drle_pkg::HP_CFG_W-1:0]   hp_cfg_r;
  logic [drle_pkg::THR_W-1:0]      thr_r;

  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [drle_pkg::BLKNUM_W-1:0]   blk_r, blk_nxt;
  logic [drle_pkg::RUN_W-1:0]      run_r, run_nxt;

  logic [5:0]                      side6;
  logic [SW-1:0]                   side_c;
  logic [TW-1:0]                   side_w;
  logic [TW-1:0]                   total_c;
  logic [CMPW-1:0]                 total_x, hp_x, pos_x, pos_inc;
  logic [drle_pkg::COEFF_W:0]      cx, mag;
  logic [drle_pkg::RUN_W-1:0]      run_mid;
  logic                            accept, blk_end, keep, is_hi;
  drle_pkg::task_t                 t;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    // Block side saturated to [1, MAX_BLOCK_SIDE], then the square.
    side6 = {1'b0, side_cfg_r};
    if (side6 == 6'd0) begin
      side6 = 6'd1;
    end else if (side6 > 6'(MAX_BLOCK_SIDE)) begin
      side6 = 6'(MAX_BLOCK_SIDE);
    end
    side_c  = SW'(side6);
    side_w  = TW'(side_c);
    total_c = side_w * side_w;
    total_x = CMPW'(total_c);

    hp_x = CMPW'(hp_cfg_r);
    if (hp_x > total_x) begin
      hp_x = total_x;
    end
    pos_x   = CMPW'(pos_r);
    pos_inc = pos_x + CMPW'(1);

    cx  = {in_coeff[drle_pkg::COEFF_W-1], in_coeff};
    mag = cx[drle_pkg::COEFF_W] ? (~cx + 1'b1) : cx;

    is_hi   = pos_x < hp_x;
    keep    = mag >= {1'b0, thr_r};
    blk_end = pos_inc >= total_x;

    t       = '0;
    t.coeff = in_coeff;
    t.blk   = blk_r;
    run_mid = run_r;

    if (hp_x == '0 && pos_x == '0) begin
      t.mask[drle_pkg::SL_BS_PRE] = 1'b1;
      t.mask[drle_pkg::SL_BN_PRE] = 1'b1;
    end

    if (is_hi) begin
      t.mask[drle_pkg::SL_HI] = 1'b1;
      if (pos_inc == hp_x) begin
        t.mask[drle_pkg::SL_BS_POST] = 1'b1;
        t.mask[drle_pkg::SL_BN_POST] = 1'b1;
      end
    end else if (keep) begin
      if (run_r != '0) begin
        t.mask[drle_pkg::SL_RL_PRE] = 1'b1;
      end
      t.mask[drle_pkg::SL_LO] = 1'b1;
      run_mid = '0;
    end else begin
      if (run_r != '0) begin
        t.mask[drle_pkg::SL_RS] = 1'b0;
      end else begin
        t.mask[drle_pkg::SL_RS] = 1'b1;
      end
      run_mid = run_r + 1'b1;
    end

    // A run open at the block end is closed; the kept case never leaves one.
    t.run   = t.mask[drle_pkg::SL_RL_PRE] ? run_r : run_mid;
    run_nxt = run_mid;
    blk_nxt = blk_r;
    pos_nxt = PW'(pos_inc);
    if (blk_end) begin
      if (run_mid != '0) begin
        t.mask[drle_pkg::SL_RL_END] = 1'b1;
      end
      run_nxt = '0;
      blk_nxt = blk_r + 1'b1;
      pos_nxt = '0;
    end
  end

  assign q_push = accept && (t.mask != '0);
  assign q_task = t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_cfg_r <= drle_pkg::SIDE_CFG_W'(8);
      hp_cfg_r   <= drle_pkg::HP_CFG_W'(1);
      thr_r      <= '0;
      pos_r      <= '0;
      blk_r      <= '0;
      run_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          drle_pkg::CFG_BLOCK_SIDE: side_cfg_r <= cfg_data[drle_pkg::SIDE_CFG_W-1:0];
          drle_pkg::CFG_HI_COUNT:   hp_cfg_r   <= cfg_data[drle_pkg::HP_CFG_W-1:0];
          drle_pkg::CFG_THRESHOLD:  thr_r      <= cfg_data[drle_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        pos_r <= pos_nxt;
        blk_r <= blk_nxt;
        run_r <= run_nxt;
      end
    end
  end

endmodule

@@ rtl/drle_queue.sv @@
// Short task queue between the front end and the result sequencer.
// Depends on drle_pkg.
`timescale 1ns / 1ps

module drle_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  drle_pkg::task_t push_task,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output drle_pkg::task_t head_task
);

  drle_pkg::task_t                mem_r [drle_pkg::QDEPTH];
  logic [drle_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [drle_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_pop;

  assign full       = cnt_r == drle_pkg::QCNT_W'(drle_pkg::QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_task  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/drle_back.sv @@
// Result sequencer: walks the result slots of one task, one result per cycle unless
// out_stall holds it, into the output register. Depends on drle_pkg.
`timescale 1ns / 1ps

module drle_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  drle_pkg::task_t                      q_task,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [drle_pkg::KIND_W-1:0]          out_kind,
  output logic signed [drle_pkg::COEFF_W-1:0]  out_coeff_out,
  output logic [drle_pkg::BLKNUM_W-1:0]        out_count_out,
  output logic                                 out_last_of_item
);

  logic                                 cur_valid_r, cur_valid_nxt;
  drle_pkg::task_t                      cur_r, cur_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  drle_pkg::kind_t                      kind_r, kind_nxt;
  logic signed [drle_pkg::COEFF_W-1:0]  coeff_r, coeff_nxt;
  logic [drle_pkg::BLKNUM_W-1:0]        count_r, count_nxt;
  logic                                 last_r, last_nxt;

  logic                                 adv;
  logic [drle_pkg::SLOT_IDX_W-1:0]      idx;
  logic [drle_pkg::NSLOT-1:0]           rem;
  drle_pkg::kind_t                      k;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    idx = '0;
    for (int i = drle_pkg::NSLOT - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) begin
        idx = drle_pkg::SLOT_IDX_W'(i);
      end
    end
    rem = cur_r.mask & (cur_r.mask - 1'b1);
    k   = drle_pkg::slot_kind(idx);

    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    coeff_nxt     = coeff_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;

    if (adv) begin
      out_valid_nxt = cur_valid_r;
      if (cur_valid_r) begin
        kind_nxt  = k;
        coeff_nxt = (k == drle_pkg::KIND_HI || k == drle_pkg::KIND_LO) ? cur_r.coeff : '0;
        case (k)
          drle_pkg::KIND_BLOCK_NUM: count_nxt = cur_r.blk;
          drle_pkg::KIND_RUN_LEN:   count_nxt = drle_pkg::BLKNUM_W'(cur_r.run);
          default:                  count_nxt = '0;
        endcase
        last_nxt = rem == '0;
        if (rem == '0) begin
          // Take the next task in the same cycle so results stay back to back.
          q_pop         = q_valid;
          cur_valid_nxt = q_valid;
          cur_nxt       = q_task;
        end else begin
          cur_nxt.mask = rem;
        end
      end
    end

    if (!cur_valid_r && q_valid) begin
      q_pop         = 1'b1;
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r   <= cur_nxt;
    kind_r  <= kind_nxt;
    coeff_r <= coeff_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_coeff_out    = coeff_r;
  assign out_count_out    = count_r;
  assign out_last_of_item = last_r;

endmodule
